### src/iees_pkg.sv
`default_nettype none

package iees_pkg;

    localparam int unsigned STACK_BYTES_DEF = 4096;
    localparam int unsigned NUM_LINES_DEF   = 16;

    localparam logic [31:0] RETURN_MARK = 32'hFFFF_FFFF;
    localparam int unsigned FRAME_BYTES = 29;
    localparam int unsigned FRAME_W     = 8 * FRAME_BYTES;

    localparam logic [1:0] KIND_NONE   = 2'b00;
    localparam logic [1:0] KIND_RETURN = 2'b01;
    localparam logic [1:0] KIND_ENTRY  = 2'b10;

    typedef struct packed {
        logic [15:0] request_mask;
        logic [31:0] r0_in;
        logic [31:0] r1_in;
        logic [31:0] r2_in;
        logic [31:0] r3_in;
        logic [31:0] r12_in;
        logic [31:0] lr_in;
        logic [31:0] pc_in;
        logic [31:0] sp_in;
        logic [3:0]  flags_in;
    } req_item_t;

    typedef struct packed {
        logic [31:0] r0_out;
        logic [31:0] r1_out;
        logic [31:0] r2_out;
        logic [31:0] r3_out;
        logic [31:0] r12_out;
        logic [31:0] lr_out;
        logic [31:0] pc_out;
        logic [31:0] sp_out;
        logic [3:0]  flags_out;
        logic        handler_active;
        logic [1:0]  event_kind;
    } rsp_item_t;

    // Stack frame image, first byte in memory is the MSB.
    typedef struct packed {
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        logic [31:0] r12;
        logic [31:0] lr;
        logic [31:0] pc;
        logic [7:0]  fbyte;
    } frame_t;

    typedef struct packed {
        logic start;
        logic inc;
    } addr_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REDUCE,
        ST_POP,
        ST_PUSH,
        ST_FINISH
    } state_t;

    typedef enum logic {
        OP_POP,
        OP_PUSH
    } op_t;

endpackage

`default_nettype wire

### src/iees_stack_ram.sv
`default_nettype none

module iees_stack_ram #(
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]               wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/iees_addr_unit.sv
`default_nettype none

// Byte index generator: reduces a 32-bit address modulo the stack size
// (a mask for a power-of-two size, otherwise a reciprocal multiply, a
// multiply-subtract and one compare-subtract, each a registered step), then steps
// through consecutive bytes. The index returns to zero where the stack size
// wraps and where the 32-bit address itself wraps.
module iees_addr_unit #(
    parameter int unsigned STACK_BYTES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire iees_pkg::addr_ctl_t            ctl,
    input  wire logic [31:0]                    value,
    output logic                                ready,
    output logic      [$clog2(STACK_BYTES)-1:0] idx
);
    import iees_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STACK_BYTES);
    localparam bit IS_POW2 = ((STACK_BYTES & (STACK_BYTES - 1)) == 0);
    localparam logic [31:0]       MODULUS = 32'(STACK_BYTES);
    // floor(2^32 / size): quotient estimate is low by at most one
    localparam logic [31:0]       RECIP   = 32'((64'd1 << 32) / 64'(STACK_BYTES));
    localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(STACK_BYTES - 1);

    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [31:0]       val_reg, val_next;
    logic [63:0]       prod_reg, prod_next;
    logic [31:0]       diff_reg, diff_next;
    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;

    always_comb
    begin
        rem_next  = rem_reg;
        val_next  = val_reg;
        prod_next = prod_reg;
        diff_next = diff_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            val_next = value;
            if (IS_POW2)
            begin
                rem_next  = value[ADDR_W-1:0];
                busy_next = 1'b0;
            end
            else
            begin
                step_next = 2'd2;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd2)
            begin
                // quotient estimate
                prod_next = 64'(val_reg) * 64'(RECIP);
                step_next = step_reg - 2'd1;
            end
            else if (step_reg == 2'd1)
            begin
                // remainder estimate, below twice the size
                diff_next = val_reg - prod_reg[63:32] * MODULUS;
                step_next = step_reg - 2'd1;
            end
            else
            begin
                if (diff_reg >= MODULUS)
                begin
                    rem_next = ADDR_W'(diff_reg - MODULUS);
                end
                else
                begin
                    rem_next = diff_reg[ADDR_W-1:0];
                end
                busy_next = 1'b0;
            end
        end
        else if (ctl.inc)
        begin
            val_next = val_reg + 32'd1;
            rem_next = (rem_reg == LAST || val_reg == 32'hFFFF_FFFF) ? '0 : rem_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        prod_reg <= prod_next;
        diff_reg <= diff_next;
    end

    assign ready = !busy_reg;
    assign idx   = rem_reg;

endmodule

`default_nettype wire

### src/interrupt_entry_exit_stacker.sv
`default_nettype none

// Interrupt entry/exit stacker.
// Request channel (req_valid/req_ready/req) carries the CPU register set and
// new interrupt requests; response channel (rsp_valid/rsp_ready/rsp) returns
// the updated register set, the handler-active flag and the event kind.
// One item is in work at a time; req_ready is high only while idle.
// After the request transfer the block decides what happens: nothing, a
// return (29-byte pop), an entry (29-byte push) or return-then-entry, all
// through a byte-wide private stack RAM, one byte per cycle; the result then
// goes to the output register. The next item is taken only after the result
// is handed to the output register.
// For a stack size that is not a power of two, each frame base goes through
// a three-step reciprocal-multiply reduction before its pop or push.
// Reset clears the pending lines, the active flag and all control state; the
// stack RAM contents are left as they are.
// A finished result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result waits inside the block
// until the output register frees, and no further item is taken meanwhile.
module interrupt_entry_exit_stacker #(
    parameter int unsigned STACK_BYTES = iees_pkg::STACK_BYTES_DEF,
    parameter int unsigned NUM_LINES   = iees_pkg::NUM_LINES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire iees_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output iees_pkg::rsp_item_t      rsp
);
    import iees_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STACK_BYTES);
    localparam int unsigned LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [31:0] FRAME_SZ = 32'(FRAME_BYTES);
    localparam logic [4:0]  LAST_BYTE = 5'(FRAME_BYTES - 1);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    frame_t                 frame_reg, frame_next;
    logic [31:0]            sp_reg, sp_next;
    logic [NUM_LINES-1:0]   pend_reg, pend_next;
    logic                   act_reg, act_next;
    logic [1:0]             kind_reg, kind_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [4:0]             cnt_reg, cnt_next;
    rsp_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    // lowest pending line
    logic                   any_pend;
    logic [LINE_W-1:0]      low_line;
    logic [31:0]            mask_ext;

    // stack RAM and address unit
    addr_ctl_t              actl;
    logic [31:0]            aval;
    logic                   a_ready;
    logic [ADDR_W-1:0]      a_idx;
    logic                   wr_en;
    logic [7:0]             rd_data;

    frame_t                 shifted;

    assign mask_ext = {16'b0, req.request_mask};

    always_comb
    begin
        any_pend = |pend_reg;
        low_line = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                low_line = LINE_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        frame_next     = frame_reg;
        sp_next        = sp_reg;
        pend_next      = pend_reg;
        act_next       = act_reg;
        kind_next      = kind_reg;
        line_next      = line_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        actl           = '0;
        aval           = sp_reg;
        wr_en          = 1'b0;
        shifted        = frame_t'({frame_reg[FRAME_W-9:0], rd_data});
        req_ready      = (state_reg == ST_IDLE);

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    frame_next.r0    = req.r0_in;
                    frame_next.r1    = req.r1_in;
                    frame_next.r2    = req.r2_in;
                    frame_next.r3    = req.r3_in;
                    frame_next.r12   = req.r12_in;
                    frame_next.lr    = req.lr_in;
                    frame_next.pc    = req.pc_in;
                    frame_next.fbyte = {4'b0, req.flags_in};
                    sp_next          = req.sp_in;
                    pend_next        = pend_reg | mask_ext[NUM_LINES-1:0];
                    kind_next        = KIND_NONE;
                    state_next       = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (act_reg && frame_reg.pc == RETURN_MARK)
                begin
                    actl.start = 1'b1;
                    aval       = sp_reg;
                    op_next    = OP_POP;
                    state_next = ST_REDUCE;
                end
                else if (!act_reg && any_pend)
                begin
                    actl.start = 1'b1;
                    aval       = sp_reg - FRAME_SZ;
                    op_next    = OP_PUSH;
                    line_next  = low_line;
                    state_next = ST_REDUCE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_REDUCE:
            begin
                if (a_ready)
                begin
                    cnt_next   = '0;
                    state_next = (op_reg == OP_POP) ? ST_POP : ST_PUSH;
                end
            end

            ST_POP:
            begin
                // read issued for byte cnt, data of byte cnt-1 arrives
                actl.inc = (cnt_reg != 5'(FRAME_BYTES));
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg != '0)
                begin
                    frame_next = shifted;
                end
                if (cnt_reg == 5'(FRAME_BYTES))
                begin
                    frame_next.fbyte[7:4] = 4'b0;
                    sp_next    = sp_reg + FRAME_SZ;
                    act_next   = 1'b0;
                    kind_next  = kind_reg | KIND_RETURN;
                    state_next = ST_DECIDE;
                end
            end

            ST_PUSH:
            begin
                wr_en      = 1'b1;
                actl.inc   = 1'b1;
                cnt_next   = cnt_reg + 5'd1;
                frame_next = frame_t'({frame_reg[FRAME_W-9:0], frame_reg[FRAME_W-1 -: 8]});
                if (cnt_reg == LAST_BYTE)
                begin
                    frame_next.lr       = RETURN_MARK;
                    frame_next.pc       = {{(32 - LINE_W){1'b0}}, line_reg} + 32'd1;
                    sp_next             = sp_reg - FRAME_SZ;
                    act_next            = 1'b1;
                    pend_next[line_reg] = 1'b0;
                    kind_next           = kind_reg | KIND_ENTRY;
                    state_next          = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next.r0_out         = frame_reg.r0;
                    out_next.r1_out         = frame_reg.r1;
                    out_next.r2_out         = frame_reg.r2;
                    out_next.r3_out         = frame_reg.r3;
                    out_next.r12_out        = frame_reg.r12;
                    out_next.lr_out         = frame_reg.lr;
                    out_next.pc_out         = frame_reg.pc;
                    out_next.sp_out         = sp_reg;
                    out_next.flags_out      = frame_reg.fbyte[3:0];
                    out_next.handler_active = act_reg;
                    out_next.event_kind     = kind_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_POP;
            pend_reg      <= '0;
            act_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pend_reg      <= pend_next;
            act_reg       <= act_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        sp_reg    <= sp_next;
        kind_reg  <= kind_next;
        line_reg  <= line_next;
        out_reg   <= out_next;
    end

    iees_addr_unit #(
        .STACK_BYTES (STACK_BYTES)
    ) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (actl),
        .value (aval),
        .ready (a_ready),
        .idx   (a_idx)
    );

    iees_stack_ram #(
        .DEPTH (STACK_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (a_idx),
        .wr_data (frame_reg[FRAME_W-1 -: 8]),
        .rd_addr (a_idx),
        .rd_data (rd_data)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
